### hw/rtl/cle_pkg.sv
// Shared types, constants and helper functions for the character LCD
// expander sequencer. No dependencies.
`timescale 1ns / 1ps

package cle_pkg;

  localparam int COLUMNS = 16;
  localparam int ROWS    = 2;
  localparam int COL_W   = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;

  localparam logic [7:0] BIT_RS    = 8'h01;
  localparam logic [7:0] BIT_EN    = 8'h04;
  localparam logic [7:0] BIT_BL    = 8'h08;
  localparam logic [7:0] CMD_CLEAR = 8'h01;
  localparam logic [7:0] CMD_HOME  = 8'h02;
  localparam logic [7:0] CMD_DDRAM = 8'h80;
  localparam logic [7:0] ROW1_BASE = 8'h40;
  localparam logic [7:0] CHAR_LF   = 8'h0A;
  localparam logic [7:0] CHAR_CR   = 8'h0D;

  localparam logic [13:0] DLY_WRITE  = 14'd0;
  localparam logic [13:0] DLY_EN_HI  = 14'd1;
  localparam logic [13:0] DLY_EN_LO  = 14'd50;
  localparam logic [13:0] DLY_CMD    = 14'd150;
  localparam logic [13:0] DLY_LONG   = 14'd5050;
  localparam logic [13:0] DLY_CLEAR  = 14'd10050;

  // Beats of one item are numbered 0..11; the final beat is always 11.
  localparam logic [3:0] STEP_FULL   = 4'd0;
  localparam logic [3:0] STEP_HALF   = 4'd6;
  localparam logic [3:0] STEP_SINGLE = 4'd11;
  localparam logic [3:0] STEP_LAST   = 4'd11;

  typedef enum logic [1:0] {
    MODE_PRINT     = 2'd0,
    MODE_CLEAR     = 2'd1,
    MODE_CURSOR    = 2'd2,
    MODE_BACKLIGHT = 2'd3
  } mode_e;

  // Wait on the final EN-low beat of a byte.
  typedef enum logic [1:0] {
    TAIL_DATA  = 2'd0,
    TAIL_CMD   = 2'd1,
    TAIL_LONG  = 2'd2,
    TAIL_CLEAR = 2'd3
  } tail_e;

  typedef struct packed {
    logic [7:0] byte0;
    logic       rs0;
    tail_e      tail0;
    logic [7:0] byte1;
    logic       rs1;
    tail_e      tail1;
    logic       bl;
    logic       single;
    logic [3:0] start_step;
  } job_t;

  typedef struct packed {
    logic             row;
    logic [COL_W-1:0] col;
  } cursor_t;

  function automatic logic [13:0] tail_delay(tail_e t);
    logic [13:0] d;
    unique case (t)
      TAIL_DATA:  d = DLY_EN_LO;
      TAIL_CMD:   d = DLY_CMD;
      TAIL_LONG:  d = DLY_LONG;
      TAIL_CLEAR: d = DLY_CLEAR;
      default:    d = DLY_EN_LO;
    endcase
    return d;
  endfunction

  function automatic logic [7:0] cursor_cmd(logic row, logic [COL_W-1:0] col);
    logic [7:0] addr;
    addr = {{(8 - COL_W){1'b0}}, col} + (row ? ROW1_BASE : 8'h00);
    return CMD_DDRAM | (addr & 8'h7F);
  endfunction

  function automatic logic next_row(logic row);
    return (ROWS > 1) ? ~row : 1'b0;
  endfunction

endpackage

### hw/rtl/char_lcd_expander_sequencer.sv
// Top level of the character LCD expander sequencer: input handshake, beat
// sequencer and output register. Depends on cle_pkg and cle_decode.
`timescale 1ns / 1ps

//  channel | signals                                     | dir
//  --------+---------------------------------------------+-----
//  in      | in_valid_i, in_ready_o, mode_i, value_i,    | in
//          | row_request_i, col_request_i                |
//  out     | out_valid_o, out_ready_i, expander_byte_o,  | out
//          | delay_us_o, last_o                          |
//
// An item yields 1, 6 or 12 beats, one beat per cycle from the beat counter while
// the output is not stalled; the next item is taken in the cycle its
// predecessor's final beat moves to the output register.
// Reset sets the cursor to row 0, column 0 and the backlight on.
// A stalled output holds its beat; the sequencer and the input wait with it.

module char_lcd_expander_sequencer import cle_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  mode_i,
  input  logic [7:0]  value_i,
  input  logic [7:0]  row_request_i,
  input  logic [7:0]  col_request_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  expander_byte_o,
  output logic [13:0] delay_us_o,
  output logic        last_o
);

  cursor_t     cur_q, cur_d;
  logic        bl_q, bl_d;
  job_t        job_q, job_d;
  logic        job_valid_q;
  logic [3:0]  step_q;
  logic        out_valid_q;
  logic [7:0]  byte_q;
  logic [13:0] delay_q;
  logic        last_q;

  logic        emit;
  logic        final_beat;
  logic        in_acc;
  logic        half;
  logic [3:0]  sub;
  logic        nib;
  logic [1:0]  phase;
  logic [7:0]  src;
  logic        rs;
  tail_e       tail;
  logic [7:0]  beat_byte;
  logic [13:0] beat_delay;

  cle_decode u_decode (
    .mode_i        (mode_i),
    .value_i       (value_i),
    .row_request_i (row_request_i),
    .col_request_i (col_request_i),
    .cur_i         (cur_q),
    .bl_i          (bl_q),
    .job_o         (job_d),
    .cur_o         (cur_d),
    .bl_o          (bl_d)
  );

  assign emit       = job_valid_q && (!out_valid_q || out_ready_i);
  assign final_beat = (step_q == STEP_LAST);
  assign in_ready_o = !job_valid_q || (emit && final_beat);
  assign in_acc     = in_valid_i && in_ready_o;

  // Beat number splits into byte half, nibble and EN phase.
  always_comb begin
    half  = (step_q >= STEP_HALF);
    sub   = half ? (step_q - STEP_HALF) : step_q;
    nib   = (sub >= 4'd3);
    phase = nib ? 2'(sub - 4'd3) : sub[1:0];
    src   = half ? job_q.byte1 : job_q.byte0;
    rs    = half ? job_q.rs1 : job_q.rs0;
    tail  = half ? job_q.tail1 : job_q.tail0;
    beat_byte = ((nib ? {src[3:0], 4'h0} : {src[7:4], 4'h0})) | (job_q.bl ? BIT_BL : 8'h00)
              | (rs ? BIT_RS : 8'h00);
    beat_delay = DLY_WRITE;
    unique case (phase)
      2'd1: begin
        beat_byte  = beat_byte | BIT_EN;
        beat_delay = DLY_EN_HI;
      end
      2'd2: beat_delay = nib ? tail_delay(tail) : DLY_EN_LO;
      default: beat_delay = DLY_WRITE;
    endcase
    if (job_q.single) begin
      beat_byte  = job_q.bl ? BIT_BL : 8'h00;
      beat_delay = DLY_WRITE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q       <= '0;
      bl_q        <= 1'b1;
      job_valid_q <= 1'b0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        cur_q       <= cur_d;
        bl_q        <= bl_d;
        job_valid_q <= 1'b1;
        step_q      <= job_d.start_step;
      end else if (emit) begin
        if (final_beat) begin
          job_valid_q <= 1'b0;
        end else begin
          step_q <= step_q + 4'd1;
        end
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      job_q <= job_d;
    end
    if (emit) begin
      byte_q  <= beat_byte;
      delay_q <= beat_delay;
      last_q  <= final_beat;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign expander_byte_o = byte_q;
  assign delay_us_o      = delay_q;
  assign last_o          = last_q;

  // An accepted item always leaves a beat plan behind.
  a_accept_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> job_valid_q)
    else $error("accepted item left no active beat plan");

  // The beat counter never runs past the final beat.
  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_valid_q |-> (step_q <= STEP_LAST))
    else $error("beat counter beyond final beat");

  // With no plan active and the output drained, no beat appears.
  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!job_valid_q && (!out_valid_q || out_ready_i)) |=> !out_valid_q)
    else $error("beat issued without an active item");

endmodule

### hw/rtl/cle_decode.sv
// Turns one input item and the current cursor and backlight into a beat
// plan and the state that follows the item. Depends on cle_pkg.
`timescale 1ns / 1ps

module cle_decode import cle_pkg::*; (
  input  logic [1:0] mode_i,
  input  logic [7:0] value_i,
  input  logic [7:0] row_request_i,
  input  logic [7:0] col_request_i,
  input  cursor_t    cur_i,
  input  logic       bl_i,
  output job_t       job_o,
  output cursor_t    cur_o,
  output logic       bl_o
);

  logic [COL_W:0]   col_inc;
  logic             wrap_row;
  logic             clamp_row;
  logic [COL_W-1:0] clamp_col;

  assign col_inc   = {1'b0, cur_i.col} + {{COL_W{1'b0}}, 1'b1};
  assign wrap_row  = next_row(cur_i.row);
  assign clamp_row = (row_request_i >= 8'(ROWS)) ? 1'(ROWS - 1) : row_request_i[0];
  assign clamp_col = (col_request_i >= 8'(COLUMNS)) ? COL_W'(COLUMNS - 1)
                                                    : col_request_i[COL_W-1:0];

  always_comb begin
    job_o            = '0;
    job_o.tail0      = TAIL_DATA;
    job_o.tail1      = TAIL_CMD;
    job_o.bl         = bl_i;
    job_o.start_step = STEP_HALF;
    cur_o            = cur_i;
    bl_o             = bl_i;
    unique case (mode_e'(mode_i))
      MODE_PRINT: begin
        if (value_i == CHAR_LF) begin
          cur_o.row   = wrap_row;
          cur_o.col   = '0;
          job_o.byte1 = cursor_cmd(wrap_row, '0);
        end else if (value_i == CHAR_CR) begin
          cur_o.col   = '0;
          job_o.byte1 = cursor_cmd(cur_i.row, '0);
        end else if (col_inc >= (COL_W + 1)'(COLUMNS)) begin
          // Last column written: data byte, then cursor to the next row.
          cur_o.row        = wrap_row;
          cur_o.col        = '0;
          job_o.byte0      = value_i;
          job_o.rs0        = 1'b1;
          job_o.byte1      = cursor_cmd(wrap_row, '0);
          job_o.start_step = STEP_FULL;
        end else begin
          cur_o.col   = col_inc[COL_W-1:0];
          job_o.byte1 = value_i;
          job_o.rs1   = 1'b1;
          job_o.tail1 = TAIL_DATA;
        end
      end
      MODE_CLEAR: begin
        cur_o            = '0;
        job_o.byte0      = CMD_CLEAR;
        job_o.tail0      = TAIL_CLEAR;
        job_o.byte1      = CMD_HOME;
        job_o.tail1      = TAIL_LONG;
        job_o.start_step = STEP_FULL;
      end
      MODE_CURSOR: begin
        cur_o.row   = clamp_row;
        cur_o.col   = clamp_col;
        job_o.byte1 = cursor_cmd(clamp_row, clamp_col);
      end
      MODE_BACKLIGHT: begin
        bl_o             = |value_i;
        job_o.bl         = |value_i;
        job_o.single     = 1'b1;
        job_o.start_step = STEP_SINGLE;
      end
      default: ;
    endcase
  end

endmodule
